// File: rtl/tdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Shared widths, constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tdf_pkg;

   localparam int VALUE_WIDTH  = 50;
   localparam int DIV_WIDTH    = 26;
   localparam int EXP_WIDTH    = 6;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = $clog2(VALUE_WIDTH);

   // Candidates below this bound stand in for the small prime table.
   localparam logic [DIV_WIDTH-1:0] SMALL_LIMIT = DIV_WIDTH'(65536);
   localparam logic [DIV_WIDTH-1:0] WHEEL_START = DIV_WIDTH'(65537);
   localparam logic [DIV_WIDTH-1:0] WHEEL_LIMIT = DIV_WIDTH'(33554432);
   localparam int PRIME32_BIT = 32;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_PAIR   = 2'd0,
      STATUS_ONE    = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_END,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/tdf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer divider
// Restoring divider, one quotient bit per cycle, quotient and remainder held.
// ----------------------------------------------------------------------------
module tdf_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                div_start,
   input  logic [tdf_pkg::VALUE_WIDTH-1:0]     dividend,
   input  logic [tdf_pkg::DIV_WIDTH-1:0]       divisor,
   output logic                                div_done,
   output logic [tdf_pkg::VALUE_WIDTH-1:0]     quotient,
   output logic [tdf_pkg::DIV_WIDTH-1:0]       remainder
);
   import tdf_pkg::*;

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [DIV_WIDTH:0]     trial;
   logic [DIV_WIDTH:0]     diff;
   logic                   fits;

   // The accumulator shifts the dividend out at the top and the quotient in.
   assign trial = {rem_ff, acc_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_start) begin
         acc_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = {acc_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == COUNT_WIDTH'(VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done  = done_ff;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/trial_division_factorizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer
// Emits the prime factorization of a 50-bit value as (prime, exponent) items.
// ----------------------------------------------------------------------------
// One value is taken when start is high and busy is low; busy then stays high
// until the run of result items is complete. Results appear one per rsp_valid
// pulse in ascending order of prime, the final one with rsp_last set, and they
// cannot be held off. All trial divisions run through one shared restoring
// divider; the work for a value grows with the number of trial divisions:
// one per candidate plus one more for each time a factor divides, up to about
// 11 million candidates for a 50-bit value with two large prime factors.
// Values zero and one keep busy low, and their status item follows in the
// cycle after the value.
module trial_division_factorizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tdf_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic [tdf_pkg::VALUE_WIDTH-1:0]     rsp_prime_base,
   output logic [tdf_pkg::EXP_WIDTH-1:0]       rsp_exponent,
   output logic [tdf_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic                                rsp_last
);
   import tdf_pkg::*;

   state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   d_ff, d_in;
   logic [EXP_WIDTH-1:0]   exp_ff, exp_in;
   logic                   minus_ff, minus_in;
   logic                   chk_ff, chk_in;
   logic                   phase_b_ff, phase_b_in;

   logic                   pend_valid_ff, pend_valid_in;
   logic [VALUE_WIDTH-1:0] pend_base_ff, pend_base_in;
   logic [EXP_WIDTH-1:0]   pend_exp_ff, pend_exp_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_base_ff, rsp_base_in;
   logic [EXP_WIDTH-1:0]    rsp_exp_ff, rsp_exp_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                   div_start, div_done;
   logic [VALUE_WIDTH-1:0] quotient;
   logic [DIV_WIDTH-1:0]   remainder;

   logic                   too_big, divides, rem_one, rem_small;
   logic [DIV_WIDTH-1:0]   nd;
   logic                   nd_minus, a_over, b_over, phase_done;
   logic                   produce;
   logic [VALUE_WIDTH-1:0] prod_base;
   logic [EXP_WIDTH-1:0]   prod_exp;

   tdf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (rem_ff),
      .divisor   (d_ff),
      .div_done  (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // A quotient below the divisor means divisor squared exceeds the remainder.
   assign too_big   = quotient < VALUE_WIDTH'(d_ff);
   assign divides   = remainder == '0;
   assign rem_one   = rem_ff == VALUE_WIDTH'(1);
   assign rem_small = rem_ff[VALUE_WIDTH-1:PRIME32_BIT] == '0;

   // Candidates run 2, 3, then 6k-1 and 6k+1.
   always_comb begin
      if (d_ff == DIV_WIDTH'(2)) begin
         nd       = DIV_WIDTH'(3);
         nd_minus = 1'b0;
      end else if (d_ff == DIV_WIDTH'(3)) begin
         nd       = DIV_WIDTH'(5);
         nd_minus = 1'b1;
      end else begin
         nd       = minus_ff ? d_ff + DIV_WIDTH'(2) : d_ff + DIV_WIDTH'(4);
         nd_minus = ~minus_ff;
      end
   end

   assign a_over     = nd >= SMALL_LIMIT;
   assign b_over     = nd_minus && (nd >= WHEEL_LIMIT);
   assign phase_done = phase_b_ff ? b_over : a_over;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_value > VALUE_WIDTH'(1))) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               if (chk_ff && too_big) begin
                  state_in = ST_END;
               end else if (divides) begin
                  state_in = ST_LAUNCH;
               end else if (phase_done) begin
                  state_in = ST_END;
               end else begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_END: begin
            if (phase_b_ff || rem_one || rem_small) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LAUNCH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rem_in     = rem_ff;
      d_in       = d_ff;
      exp_in     = exp_ff;
      minus_in   = minus_ff;
      chk_in     = chk_ff;
      phase_b_in = phase_b_ff;
      div_start  = 1'b0;
      produce    = 1'b0;
      prod_base  = VALUE_WIDTH'(d_ff);
      prod_exp   = exp_ff;

      pend_valid_in = pend_valid_ff;
      pend_base_in  = pend_base_ff;
      pend_exp_in   = pend_exp_ff;

      rsp_valid_in  = 1'b0;
      rsp_base_in   = rsp_base_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_value == '0 || req_value == VALUE_WIDTH'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_base_in   = '0;
                  rsp_exp_in    = '0;
                  rsp_status_in = (req_value == '0) ? STATUS_REJECT : STATUS_ONE;
                  rsp_last_in   = 1'b1;
               end else begin
                  rem_in        = req_value;
                  d_in          = DIV_WIDTH'(2);
                  exp_in        = '0;
                  minus_in      = 1'b0;
                  chk_in        = 1'b1;
                  phase_b_in    = 1'b0;
                  pend_valid_in = 1'b0;
               end
            end
         end
         ST_LAUNCH: div_start = 1'b1;
         ST_WAIT: begin
            if (div_done && !(chk_ff && too_big)) begin
               if (divides) begin
                  rem_in = quotient;
                  exp_in = exp_ff + 1'b1;
                  chk_in = 1'b0;
               end else begin
                  produce  = exp_ff != '0;
                  exp_in   = '0;
                  d_in     = nd;
                  minus_in = nd_minus;
                  chk_in   = phase_b_ff ? nd_minus : 1'b1;
               end
            end
         end
         ST_END: begin
            prod_base = rem_ff;
            prod_exp  = EXP_WIDTH'(1);
            if (phase_b_ff) begin
               produce = ~rem_one;
            end else if (!rem_one) begin
               if (rem_small) begin
                  produce = 1'b1;
               end else begin
                  d_in       = WHEEL_START;
                  minus_in   = 1'b1;
                  chk_in     = 1'b0;
                  exp_in     = '0;
                  phase_b_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_base_in   = pend_base_ff;
            rsp_exp_in    = pend_exp_ff;
            rsp_status_in = STATUS_PAIR;
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase

      // Each pair waits one step so that the final one can carry last.
      if (produce) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_base_in   = pend_base_ff;
            rsp_exp_in    = pend_exp_ff;
            rsp_status_in = STATUS_PAIR;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_base_in  = prod_base;
         pend_exp_in   = prod_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rem_ff        <= '0;
         d_ff          <= '0;
         exp_ff        <= '0;
         minus_ff      <= 1'b0;
         chk_ff        <= 1'b0;
         phase_b_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rem_ff        <= rem_in;
         d_ff          <= d_in;
         exp_ff        <= exp_in;
         minus_ff      <= minus_in;
         chk_ff        <= chk_in;
         phase_b_ff    <= phase_b_in;
      end
      pend_base_ff  <= pend_base_in;
      pend_exp_ff   <= pend_exp_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_base = rsp_base_ff;
   assign rsp_exponent   = rsp_exp_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: test/trial_division_factorizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division factorizer testbench
// Sends values with known or bounded factor sizes, predicts each run of
// (prime, exponent) items by plain trial division and checks every result.
// ----------------------------------------------------------------------------
module trial_division_factorizer_unit_tb;
   import tdf_pkg::*;

   localparam longint unsigned VALUE_LIMIT = 64'd1 << VALUE_WIDTH;
   localparam int MAX_PAIRS   = 13;
   localparam int STALL_LIMIT = 4000000;

   typedef struct {
      logic [VALUE_WIDTH-1:0] prime_base;
      logic [EXP_WIDTH-1:0]   exponent;
      status_type             status;
      logic                   last;
   } factor_item;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic [VALUE_WIDTH-1:0]   req_value;
   logic                     busy;
   logic                     rsp_valid;
   logic [VALUE_WIDTH-1:0]   rsp_prime_base;
   logic [EXP_WIDTH-1:0]     rsp_exponent;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic                     rsp_last;

   factor_item pending_factors[$];
   int  failures;
   int  idle_cycles;
   bit  allow_gaps;
   longint unsigned small_primes[$];

   trial_division_factorizer_unit DUT (
      .clock(clock), .reset(reset), .start(start), .req_value(req_value),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_prime_base(rsp_prime_base),
      .rsp_exponent(rsp_exponent), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic bit is_prime(longint unsigned n);
      longint unsigned d;
      if (n < 2) return 0;
      for (d = 2; d * d <= n; d++)
         if (n % d == 0) return 0;
      return 1;
   endfunction

   function automatic void push_factor(longint unsigned base, int exp, status_type st,
                                       ref int count);
      factor_item it;
      if (count >= MAX_PAIRS) return;
      it.prime_base = base[VALUE_WIDTH-1:0];
      it.exponent   = exp[EXP_WIDTH-1:0];
      it.status     = st;
      it.last       = 1'b0;
      pending_factors.push_back(it);
      count++;
   endfunction

   // Composite divisors never divide once their prime factors are gone, so
   // plain trial division gives the same pairs as the table and the wheel.
   function automatic void predict_factors(longint unsigned value);
      longint unsigned rem;
      longint unsigned d;
      int exp;
      int count;
      count = 0;
      rem = value;
      if (rem == 0) begin
         push_factor(0, 0, STATUS_REJECT, count);
      end else if (rem == 1) begin
         push_factor(0, 0, STATUS_ONE, count);
      end else begin
         d = 2;
         while (d * d <= rem) begin
            exp = 0;
            while (rem % d == 0) begin
               rem = rem / d;
               exp++;
            end
            if (exp != 0) push_factor(d, exp, STATUS_PAIR, count);
            d = (d == 2) ? 3 : d + 2;
         end
         if (rem > 1) push_factor(rem, 1, STATUS_PAIR, count);
      end
      pending_factors[$].last = 1'b1;
   endfunction

   task automatic send_value(longint unsigned value);
      int gap;
      if (allow_gaps && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         gap = $urandom_range(1, 16);
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_value = value[VALUE_WIDTH-1:0];
      do @(posedge clock); while (busy);
      predict_factors(value);
      @(negedge clock);
   endtask

   // Builds a value from small primes, at most one prime cofactor up to 65537
   // and sometimes a power of two, keeping the trial divisions per item few.
   // The bound is checked by division so that no product can wrap past 64 bits.
   function automatic longint unsigned smooth_value();
      longint unsigned v;
      longint unsigned p;
      int k;
      v = 1;
      k = $urandom_range(1, 14);
      repeat (k) begin
         p = small_primes[$urandom_range(0, small_primes.size() - 1)];
         if (v < VALUE_LIMIT / p) v = v * p;
      end
      if ($urandom_range(0, 1) == 1) begin
         p = $urandom_range(2, 65535);
         while (!is_prime(p)) p++;
         if (v < VALUE_LIMIT / p) v = v * p;
      end
      if ($urandom_range(0, 2) == 0) begin
         p = 64'd1 << $urandom_range(1, 40);
         if (v < VALUE_LIMIT / p) v = v * p;
      end
      return v;
   endfunction

   task automatic test_special_values();
      send_value(0);
      send_value(1);
      send_value(0);
      send_value(2);
      send_value(1);
   endtask

   task automatic test_field_extremes();
      send_value(VALUE_LIMIT - 1);
      send_value(VALUE_LIMIT >> 1);
      send_value(3);
      send_value(65521);
      send_value(64'd304250263527210);   // product of the first 13 primes
      send_value(64'd1 << 32);
      send_value(64'd2 * 64'd65521 * 64'd65519);
   endtask

   task automatic test_wheel_path();
      // The remainder is at least 2^32 with no factor in the table.
      send_value(64'd65537 * 64'd65537);
   endtask

   task automatic test_random_values();
      int i;
      for (i = 0; i < 100; i++) begin
         if (i == 80) allow_gaps = 1'b0;
         send_value(smooth_value());
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_factors.size() == 0) begin
               $display("%0t: unexpected result prime_base=%0d exponent=%0d status=%0d",
                        $time, rsp_prime_base, rsp_exponent, rsp_status);
               failures++;
            end else begin
               factor_item want;
               want = pending_factors.pop_front();
               if (rsp_prime_base !== want.prime_base) begin
                  $display("%0t: prime_base expected %0d actual %0d",
                           $time, want.prime_base, rsp_prime_base);
                  failures++;
               end
               if (rsp_exponent !== want.exponent) begin
                  $display("%0t: exponent expected %0d actual %0d",
                           $time, want.exponent, rsp_exponent);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d",
                           $time, want.last, rsp_last);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      longint unsigned p;
      failures = 0;
      idle_cycles = 0;
      allow_gaps = 1'b1;
      start = 1'b0;
      req_value = '0;
      reset = 1'b1;
      for (p = 2; p < 300; p++)
         if (is_prime(p)) small_primes.push_back(p);
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_special_values();
      test_field_extremes();
      test_wheel_path();
      test_random_values();
      start = 1'b0;

      while (pending_factors.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
